>>> sv/msbls_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package msbls_pkg;
  localparam int NumSlots  = 10;
  localparam int MaxCap    = 32;
  localparam int DataWidth = 32;
  localparam int SlotW = $clog2(NumSlots + 1);
  localparam int CapW  = $clog2(MaxCap + 1);
  localparam int IdxW  = (MaxCap > 1) ? $clog2(MaxCap) : 1;
  localparam int SIdxW = (NumSlots > 1) ? $clog2(NumSlots) : 1;
  localparam int AddrW = $clog2(NumSlots * MaxCap);

  typedef enum logic [2:0] {
    MODE_CREATE = 3'd0, MODE_APPEND = 3'd1, MODE_POP = 3'd2,
    MODE_REMOVE = 3'd3, MODE_RESIZE = 3'd4, MODE_READ = 3'd5
  } mode_e;

  typedef enum logic [3:0] {
    ST_OK = 4'd0, ST_BAD_POS = 4'd1, ST_EXISTS = 4'd2, ST_BAD_SIZE = 4'd3,
    ST_NO_MEM = 4'd4, ST_NO_SLOT = 4'd5, ST_FULL = 4'd6, ST_EMPTY = 4'd7,
    ST_NOT_FOUND = 4'd8, ST_BAD_NEW = 4'd9
  } status_e;

  // controller -> datapath
  typedef struct packed {
    logic              load;     // latch request, decide
    logic              rd;       // issue memory read at scan index
    logic              shift;    // write previous read data one down
    logic              adv;      // advance scan index
    logic              commit;   // update slot tables
  } dp_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic       scan;      // request needs a walk over the list
    logic       is_read;
    logic       scan_done; // index reached count
    logic       produce;   // request gives a result
  } dp_sts_t;
endpackage
`default_nettype wire

>>> sv/msbls_datapath.sv
`timescale 1ns / 1ps
`default_nettype none
module msbls_datapath (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic [2:0]                mode_i,
  input  wire logic [3:0]                position_i,
  input  wire logic signed [31:0]        value_i,
  input  wire logic signed [7:0]         amount_i,
  input  wire msbls_pkg::dp_cmd_t        cmd_i,
  output msbls_pkg::dp_sts_t             sts_o,
  output logic [3:0]                     status_o,
  output logic signed [31:0]             element_value_o,
  output logic [6:0]                     element_count_o,
  output logic                           elem_last_o
);
  import msbls_pkg::*;

  logic [NumSlots-1:0] alloc_q;
  logic [CapW-1:0] cap_q [NumSlots];
  logic [CapW-1:0] cnt_q [NumSlots];
  logic [DataWidth-1:0] mem [NumSlots*MaxCap];

  logic [2:0] mode_q;
  logic [SIdxW-1:0] slot_q;
  logic [DataWidth-1:0] word_q;
  logic [3:0] status_q;
  logic [CapW-1:0] cnt_r_q, newcnt_q, newcap_q;
  logic upd_q, mk_q, scan_q, found_q, prod_q;
  logic [CapW-1:0] idx_q, ridx_q;
  logic rvalid_q;
  logic [DataWidth-1:0] rdata_q;

  logic pos_ok;
  logic [SIdxW-1:0] s_in;
  logic [DataWidth-1:0] word_in;
  logic [CapW-1:0] ccnt, ccap;
  logic signed [9:0] ncap;
  logic [3:0] st_d;
  logic [CapW-1:0] ncnt_d, ncap_d;
  logic upd_d, mk_d, scan_d;

  assign pos_ok = (position_i >= 4'd1) && ({1'b0, position_i} <= 5'(NumSlots));
  assign s_in = SIdxW'(position_i - 4'd1);
  assign word_in = DataWidth'($signed(value_i));
  assign ccnt = cnt_q[s_in];
  assign ccap = cap_q[s_in];
  assign ncap = $signed({4'b0000, ccap}) + 10'(amount_i);

  always_comb begin
    st_d = ST_OK; ncnt_d = ccnt; ncap_d = ccap; upd_d = 1'b0; mk_d = 1'b0;
    scan_d = 1'b0;
    if (!pos_ok) st_d = ST_BAD_POS;
    else if (mode_i == MODE_CREATE) begin
      if (alloc_q[s_in]) st_d = ST_EXISTS;
      else if (amount_i < 8'sd1) st_d = ST_BAD_SIZE;
      else if (amount_i > 8'(MaxCap)) st_d = ST_NO_MEM;
      else begin
        mk_d = 1'b1; upd_d = 1'b1; ncnt_d = '0; ncap_d = CapW'(amount_i);
      end
    end else if (!alloc_q[s_in]) st_d = ST_NO_SLOT;
    else begin
      unique case (mode_i)
        MODE_APPEND: if (ccnt >= ccap || ccnt >= CapW'(MaxCap)) st_d = ST_FULL;
                     else begin upd_d = 1'b1; ncnt_d = ccnt + 1'b1; end
        MODE_POP: if (ccnt == '0) st_d = ST_EMPTY;
                  else begin upd_d = 1'b1; ncnt_d = ccnt - 1'b1; end
        MODE_REMOVE: if (ccnt == '0) st_d = ST_EMPTY;
                     else scan_d = 1'b1;
        MODE_RESIZE: if (ncap < 10'sd1) st_d = ST_BAD_NEW;
                     else if (ncap > 10'(MaxCap)) st_d = ST_NO_MEM;
                     else begin
                       upd_d = 1'b1; ncap_d = CapW'(ncap);
                       if (ccnt > CapW'(ncap)) ncnt_d = CapW'(ncap);
                     end
        MODE_READ: scan_d = (ccnt != '0);
        default: ;
      endcase
    end
  end

  logic [AddrW-1:0] base;
  assign base = AddrW'(slot_q) * AddrW'(MaxCap);
  logic hit;
  assign hit = rvalid_q && !found_q && (rdata_q == word_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      alloc_q <= '0;
      for (int i = 0; i < NumSlots; i++) begin
        cap_q[i] <= '0; cnt_q[i] <= '0;
      end
      rvalid_q <= 1'b0; found_q <= 1'b0; prod_q <= 1'b0;
    end else begin
      rvalid_q <= cmd_i.rd;
      if (cmd_i.load) begin
        found_q <= 1'b0;
        prod_q <= (mode_i <= MODE_READ);
      end else if (hit) found_q <= 1'b1;
      if (cmd_i.commit) begin
        if (scan_q) begin
          if (found_q || hit) cnt_q[slot_q] <= cnt_r_q - 1'b1;
        end else if (upd_q) begin
          cnt_q[slot_q] <= newcnt_q; cap_q[slot_q] <= newcap_q;
          if (mk_q) alloc_q[slot_q] <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      mode_q <= mode_i; slot_q <= s_in; word_q <= word_in; status_q <= st_d;
      cnt_r_q <= (pos_ok && alloc_q[s_in]) ? ccnt : '0;
      newcnt_q <= ncnt_d; newcap_q <= ncap_d; upd_q <= upd_d; mk_q <= mk_d;
      scan_q <= scan_d && (mode_i == MODE_REMOVE || mode_i == MODE_READ);
      idx_q <= '0;
      if (mode_i == MODE_APPEND && upd_d)
        mem[AddrW'(s_in) * AddrW'(MaxCap) + AddrW'(ccnt)] <= word_in;
    end else if (cmd_i.adv) idx_q <= idx_q + 1'b1;
    if (cmd_i.rd) begin
      rdata_q <= mem[base + AddrW'(idx_q[IdxW-1:0])];
      ridx_q <= idx_q;
    end
    // after a match, each word read moves one place down
    if (cmd_i.shift && (found_q) && rvalid_q)
      mem[base + AddrW'(ridx_q[IdxW-1:0]) - 1'b1] <= rdata_q;
  end

  assign sts_o.scan = scan_q;
  assign sts_o.is_read = (mode_q == MODE_READ);
  assign sts_o.scan_done = (idx_q >= cnt_r_q);
  assign sts_o.produce = prod_q;

  logic rm_st;
  always_comb begin
    rm_st = found_q || hit;
    element_count_o = 7'(cnt_r_q);
    status_o = status_q;
    if (scan_q && mode_q == MODE_REMOVE) begin
      status_o = rm_st ? ST_OK : ST_NOT_FOUND;
      element_count_o = rm_st ? 7'(cnt_r_q - 1'b1) : 7'(cnt_r_q);
    end else if (!scan_q && upd_q) element_count_o = 7'(newcnt_q);
  end
  assign element_value_o = rdata_q;
  assign elem_last_o = (ridx_q + 1'b1 == cnt_r_q);
endmodule
`default_nettype wire

>>> sv/msbls_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
module msbls_ctrl (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                req_valid_i,
  output logic                     req_ready_o,
  input  wire msbls_pkg::dp_sts_t  sts_i,
  input  wire logic                elem_last_i,
  output msbls_pkg::dp_cmd_t       cmd_o,
  output logic                     out_go_o,
  output logic                     out_elem_o,
  output logic                     out_last_o,
  input  wire logic                out_free_i
);
  import msbls_pkg::*;

  typedef enum logic [2:0] {S_IDLE, S_DEC, S_SCAN, S_DRAIN, S_READ, S_EMIT} state_e;
  state_e state_q;

  // S_READ: rdata for one element is valid, waits for output slot
  always_comb begin
    cmd_o = '0;
    out_go_o = 1'b0; out_elem_o = 1'b0; out_last_o = 1'b1;
    req_ready_o = (state_q == S_IDLE);
    cmd_o.load = req_valid_i && req_ready_o;
    unique case (state_q)
      S_SCAN: begin
        // remove walk: read one word a cycle, shift after match; read-all fetches its first word here
        cmd_o.shift = 1'b1;
        if (!sts_i.scan_done) begin cmd_o.rd = 1'b1; cmd_o.adv = 1'b1; end
      end
      S_DRAIN: cmd_o.shift = 1'b1;
      S_READ: begin
        out_elem_o = 1'b1; out_last_o = elem_last_i;
        out_go_o = out_free_i;
        cmd_o.rd = out_free_i && !elem_last_i;
        cmd_o.adv = cmd_o.rd;
      end
      S_EMIT: begin
        out_go_o = out_free_i && sts_i.produce;
        cmd_o.commit = out_free_i || !sts_i.produce;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= S_IDLE;
    else begin
      unique case (state_q)
        S_IDLE: if (cmd_o.load) state_q <= S_DEC;
        S_DEC: state_q <= !sts_i.scan ? S_EMIT : (sts_i.is_read ? S_SCAN : S_SCAN);
        S_SCAN: begin
          if (sts_i.is_read) state_q <= S_READ;
          else if (sts_i.scan_done) state_q <= S_DRAIN;
        end
        S_DRAIN: state_q <= S_EMIT;
        S_READ: if (out_free_i && elem_last_i) state_q <= S_IDLE;
        S_EMIT: if (out_free_i || !sts_i.produce) state_q <= S_IDLE;
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load |=> state_q == S_DEC) else $error("load did not decode");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.commit |=> state_q == S_IDLE) else $error("commit without finish");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_go_o |-> out_free_i) else $error("result issued to busy output");
endmodule
`default_nettype wire

>>> sv/multi_slot_bounded_list_store.sv
`timescale 1ns / 1ps
`default_nettype none
// Ten-slot store of bounded signed word lists.
// Request channel: valid_i/ready_o with mode_i, position_i, value_i, amount_i.
// Result channel: valid_o/ready_i with status_o, element_value_o, has_value_o,
// element_count_o, last_o; last_o marks the final result of a request.
// A request is taken only when the block is idle; one request at a time.
// Create, append, pop and resize pass through the decode and emit states, then
// put their result on valid_o; the next request can be taken once it is issued.
// Remove-value walks the list through the element memory, one word a cycle,
// then drains the last shift and gives its result. Read-all fetches its first
// word and then gives one word per cycle while the receiver takes them; the
// block stays busy until the last word is issued.
// The single memory read port, one word per cycle, limits both walks.
// Modes 6 and 7 give no result and change nothing.
// Reset clears all slot tables; element memory is not cleared and needs no
// clearing pass. A stalled receiver holds the result register and the
// read-all walk pauses; no result is dropped.
module multi_slot_bounded_list_store (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               valid_i,
  output logic                    ready_o,
  input  wire logic [2:0]         mode_i,
  input  wire logic [3:0]         position_i,
  input  wire logic signed [31:0] value_i,
  input  wire logic signed [7:0]  amount_i,
  output logic                    valid_o,
  input  wire logic               ready_i,
  output logic [3:0]              status_o,
  output logic signed [31:0]      element_value_o,
  output logic                    has_value_o,
  output logic [6:0]              element_count_o,
  output logic                    last_o
);
  import msbls_pkg::*;

  dp_cmd_t cmd;
  dp_sts_t sts;
  logic [3:0] st;
  logic signed [31:0] ev;
  logic [6:0] ec;
  logic el, go, oe, ol, free;

  assign free = !valid_o || ready_i;

  msbls_ctrl u_ctrl (
    .clk_i, .rst_ni, .req_valid_i(valid_i), .req_ready_o(ready_o),
    .sts_i(sts), .elem_last_i(el), .cmd_o(cmd), .out_go_o(go),
    .out_elem_o(oe), .out_last_o(ol), .out_free_i(free)
  );

  msbls_datapath u_dp (
    .clk_i, .rst_ni, .mode_i, .position_i, .value_i, .amount_i,
    .cmd_i(cmd), .sts_o(sts), .status_o(st), .element_value_o(ev),
    .element_count_o(ec), .elem_last_o(el)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) valid_o <= 1'b0;
    else if (free) valid_o <= go;
  end

  always_ff @(posedge clk_i) begin
    if (free && go) begin
      status_o <= st;
      element_value_o <= oe ? ev : '0;
      has_value_o <= oe;
      element_count_o <= ec;
      last_o <= ol;
    end
  end
endmodule
`default_nettype wire

>>> tb/sv/multi_slot_bounded_list_store_tb.sv
`timescale 1ns / 1ps
module multi_slot_bounded_list_store_tb;
  import msbls_pkg::*;

  localparam int RandomItems = 380;
  localparam int HoldCycles  = 400;
  localparam int IdleLimit   = 3000;

  typedef struct {
    logic [2:0]  mode;
    logic [3:0]  pos;
    logic [31:0] val;
    logic [7:0]  amt;
    bit          typed;
    status_e     tstat;
  } list_req_t;

  typedef struct {
    logic [3:0]  status;
    logic [31:0] elem;
    logic        has;
    logic [6:0]  count;
    logic        last;
    bit          typed;
    status_e     tstat;
  } list_rsp_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        valid_i = 1'b0;
  logic        ready_o;
  logic [2:0]  mode_i = '0;
  logic [3:0]  position_i = '0;
  logic [31:0] value_i = '0;
  logic [7:0]  amount_i = '0;
  logic        valid_o;
  logic        ready_i = 1'b0;
  logic [3:0]  status_o;
  logic [31:0] element_value_o;
  logic        has_value_o;
  logic [6:0]  element_count_o;
  logic        last_o;

  multi_slot_bounded_list_store DUT (
    .clk_i, .rst_ni, .valid_i, .ready_o, .mode_i, .position_i, .value_i, .amount_i,
    .valid_o, .ready_i, .status_o, .element_value_o, .has_value_o, .element_count_o,
    .last_o
  );

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  // predictor state
  bit          slot_used [NumSlots];
  int          slot_cap [NumSlots];
  int          slot_fill [NumSlots];
  logic [31:0] slot_words [NumSlots][MaxCap];

  list_rsp_t pending_rsps[$];
  list_req_t cur_req;
  int  errors = 0;
  int  rsp_seen = 0;
  int  req_seen = 0;
  int  idle_cycles = 0;
  bit  hold_req = 1'b0;
  bit  hold_done = 1'b0;

  task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
    errors++;
    $display("mismatch at %0t: %s got %0h want %0h", $realtime, what, got, want);
  endtask

  task automatic push_rsp(input logic [3:0] st, input logic [31:0] el, input logic hv,
                          input int cnt, input logic lst, input list_req_t r);
    list_rsp_t e;
    e.status = st;
    e.elem = el;
    e.has = hv;
    e.count = cnt[6:0];
    e.last = lst;
    e.typed = r.typed;
    e.tstat = r.tstat;
    pending_rsps.push_back(e);
  endtask

  // apply one request to the predicted store and queue its results
  task automatic predict_list_op(input list_req_t r);
    int s;
    int amt;
    int ncap;
    int hit;
    status_e st;
    amt = $signed(r.amt);
    if (r.mode > MODE_READ) return;
    if (r.pos < 1 || r.pos > NumSlots) begin
      push_rsp(ST_BAD_POS, '0, 1'b0, 0, 1'b1, r);
      return;
    end
    s = r.pos - 1;
    if (r.mode == MODE_CREATE) begin
      if (slot_used[s]) st = ST_EXISTS;
      else if (amt < 1) st = ST_BAD_SIZE;
      else if (amt > MaxCap) st = ST_NO_MEM;
      else begin
        slot_used[s] = 1'b1;
        slot_cap[s] = amt;
        slot_fill[s] = 0;
        st = ST_OK;
      end
      push_rsp(st, '0, 1'b0, slot_used[s] ? slot_fill[s] : 0, 1'b1, r);
      return;
    end
    if (!slot_used[s]) begin
      push_rsp(ST_NO_SLOT, '0, 1'b0, 0, 1'b1, r);
      return;
    end
    st = ST_OK;
    case (r.mode)
      MODE_APPEND: begin
        if (slot_fill[s] >= slot_cap[s]) st = ST_FULL;
        else begin
          slot_words[s][slot_fill[s]] = r.val;
          slot_fill[s]++;
        end
      end
      MODE_POP: begin
        if (slot_fill[s] == 0) st = ST_EMPTY;
        else slot_fill[s]--;
      end
      MODE_REMOVE: begin
        if (slot_fill[s] == 0) st = ST_EMPTY;
        else begin
          hit = -1;
          for (int i = 0; i < slot_fill[s]; i++)
            if (hit < 0 && slot_words[s][i] == r.val) hit = i;
          if (hit < 0) st = ST_NOT_FOUND;
          else begin
            for (int j = hit; j + 1 < slot_fill[s]; j++)
              slot_words[s][j] = slot_words[s][j + 1];
            slot_fill[s]--;
          end
        end
      end
      MODE_RESIZE: begin
        ncap = slot_cap[s] + amt;
        if (ncap < 1) st = ST_BAD_NEW;
        else if (ncap > MaxCap) st = ST_NO_MEM;
        else begin
          slot_cap[s] = ncap;
          if (slot_fill[s] > ncap) slot_fill[s] = ncap;
        end
      end
      default: begin
        if (slot_fill[s] == 0) push_rsp(ST_OK, '0, 1'b0, 0, 1'b1, r);
        for (int i = 0; i < slot_fill[s]; i++)
          push_rsp(ST_OK, slot_words[s][i], 1'b1, slot_fill[s], i + 1 == slot_fill[s], r);
        return;
      end
    endcase
    push_rsp(st, '0, 1'b0, slot_fill[s], 1'b1, r);
  endtask

  // check results first, then record the request taken at this edge
  always @(posedge clk_i) begin
    list_rsp_t e;
    list_req_t r;
    if (rst_ni) begin
      if ((valid_o && ready_i) || (valid_i && ready_o)) idle_cycles = 0;
      else idle_cycles++;
      if (valid_o && ready_i) begin
        rsp_seen++;
        if (pending_rsps.size() == 0) begin
          report("unexpected result status", status_o, '0);
        end else begin
          e = pending_rsps.pop_front();
          if (status_o !== e.status) report("status", status_o, e.status);
          if (e.typed && status_o !== e.tstat) report("listed status", status_o, e.tstat);
          if (element_value_o !== e.elem) report("element_value", element_value_o, e.elem);
          if (has_value_o !== e.has) report("has_value", has_value_o, e.has);
          if (element_count_o !== e.count) report("element_count", element_count_o, e.count);
          if (last_o !== e.last) report("last", last_o, e.last);
        end
      end
      if (valid_i && ready_o) begin
        r = cur_req;
        r.mode = mode_i;
        r.pos = position_i;
        r.val = value_i;
        r.amt = amount_i;
        req_seen++;
        predict_list_op(r);
      end
    end
  end

  initial begin
    forever begin
      @(posedge clk_i);
      if (idle_cycles >= IdleLimit) begin
        $display("FAIL");
        $finish;
      end
    end
  end

  // receiver: alternate clean and stalling stretches, one long hold on request
  initial begin
    int phase;
    phase = 0;
    forever begin
      @(posedge clk_i);
      if (hold_req && !hold_done) begin
        ready_i <= 1'b0;
        repeat (HoldCycles) @(posedge clk_i);
        hold_done = 1'b1;
        ready_i <= 1'b1;
      end else begin
        phase++;
        if ((phase / 80) % 3 == 0) ready_i <= 1'b1;
        else if ((phase / 80) % 3 == 1) ready_i <= ($urandom_range(0, 3) != 0);
        else ready_i <= ($urandom_range(0, 1) != 0);
      end
    end
  end

  task automatic offer(input list_req_t r);
    cur_req <= r;
    valid_i <= 1'b1;
    mode_i <= r.mode;
    position_i <= r.pos;
    value_i <= r.val;
    amount_i <= r.amt;
    do @(posedge clk_i); while (!ready_o);
  endtask

  task automatic pause_sender();
    int gap;
    gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
    if (gap > 0) begin
      valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  function automatic list_req_t mk(input mode_e m, input int p, input logic [31:0] v,
                                   input int a, input bit t, input status_e st);
    list_req_t r;
    r.mode = m;
    r.pos = p[3:0];
    r.val = v;
    r.amt = a[7:0];
    r.typed = t;
    r.tstat = st;
    return r;
  endfunction

  // mostly well-formed requests on valid slots, some noise
  function automatic list_req_t random_req();
    list_req_t r;
    int s;
    int pick;
    r.typed = 1'b0;
    r.tstat = ST_OK;
    pick = $urandom_range(0, 99);
    r.pos = ($urandom_range(0, 9) == 0) ? 4'($urandom) : 4'($urandom_range(1, NumSlots));
    s = (r.pos >= 1 && r.pos <= NumSlots) ? r.pos - 1 : 0;
    r.val = ($urandom_range(0, 2) == 0) ? 32'($urandom_range(0, 7)) : $urandom;
    r.amt = 8'($urandom_range(1, MaxCap));
    if (pick < 6) r.mode = 3'($urandom);
    else if (pick < 16) begin
      r.mode = MODE_CREATE;
      if ($urandom_range(0, 3) == 0) r.amt = 8'($urandom);
      else if ($urandom_range(0, 2) == 0) r.amt = 8'(MaxCap);
    end else if (pick < 50) r.mode = MODE_APPEND;
    else if (pick < 58) r.mode = MODE_POP;
    else if (pick < 72) begin
      r.mode = MODE_REMOVE;
      if (slot_fill[s] > 0 && $urandom_range(0, 3) != 0)
        r.val = slot_words[s][$urandom_range(0, slot_fill[s] - 1)];
    end else if (pick < 82) begin
      r.mode = MODE_RESIZE;
      r.amt = ($urandom_range(0, 4) == 0) ? 8'($urandom) : 8'($signed($urandom_range(0, 8)) - 4);
    end else r.mode = MODE_READ;
    return r;
  endfunction

  list_req_t directed [] = '{
    mk(MODE_READ,    0, 32'h0, 0, 1, ST_BAD_POS),
    mk(MODE_APPEND, 15, 32'h0, 0, 1, ST_BAD_POS),
    mk(MODE_APPEND,  1, 32'h1, 0, 1, ST_NO_SLOT),
    mk(MODE_CREATE,  1, 32'h0, 0, 1, ST_BAD_SIZE),
    mk(MODE_CREATE,  1, 32'h0, -128, 1, ST_BAD_SIZE),
    mk(MODE_CREATE,  1, 32'h0, 33, 1, ST_NO_MEM),
    mk(MODE_CREATE,  1, 32'h0, 127, 1, ST_NO_MEM),
    mk(MODE_CREATE,  1, 32'h0, 2, 1, ST_OK),
    mk(MODE_CREATE,  1, 32'h0, 5, 1, ST_EXISTS),
    mk(MODE_READ,    1, 32'h0, 0, 1, ST_OK),
    mk(MODE_POP,     1, 32'h0, 0, 1, ST_EMPTY),
    mk(MODE_REMOVE,  1, 32'h0, 0, 1, ST_EMPTY),
    mk(MODE_APPEND,  1, 32'h8000_0000, 0, 1, ST_OK),
    mk(MODE_APPEND,  1, 32'h7fff_ffff, 0, 1, ST_OK),
    mk(MODE_APPEND,  1, 32'hffff_ffff, 0, 1, ST_FULL),
    mk(MODE_REMOVE,  1, 32'h5, 0, 1, ST_NOT_FOUND),
    mk(MODE_READ,    1, 32'h0, 0, 0, ST_OK),
    mk(MODE_RESIZE,  1, 32'h0, -2, 1, ST_BAD_NEW),
    mk(MODE_RESIZE,  1, 32'h0, 31, 1, ST_NO_MEM),
    mk(MODE_RESIZE,  1, 32'h0, -1, 0, ST_OK),
    mk(MODE_REMOVE,  1, 32'h8000_0000, 0, 1, ST_OK),
    mk(mode_e'(3'd6), 1, 32'h0, 0, 0, ST_OK),
    mk(MODE_CREATE, 10, 32'h0, 32, 1, ST_OK),
    mk(MODE_RESIZE, 10, 32'h0, -31, 1, ST_OK),
    mk(MODE_POP,    10, 32'h0, 0, 1, ST_EMPTY)
  };

  initial begin
    int burst;
    int sent;
    int waited;
    list_req_t r;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed[i]) begin
      offer(directed[i]);
      if ($urandom_range(0, 2) == 0) pause_sender();
    end

    sent = 0;
    while (sent < RandomItems) begin
      burst = $urandom_range(1, 12);
      for (int k = 0; k < burst && sent < RandomItems; k++) begin
        r = random_req();
        if (r.mode <= MODE_READ) sent++;
        if (sent == RandomItems / 3) hold_req = 1'b1;
        offer(r);
      end
      if (sent < RandomItems * 2 / 3) pause_sender();
    end
    valid_i <= 1'b0;

    waited = 0;
    while (pending_rsps.size() != 0 && waited < 20000) begin
      @(posedge clk_i);
      waited++;
    end
    repeat (40) @(posedge clk_i);

    $display("run: %0d requests taken, %0d results checked, %0d mismatches",
             req_seen, rsp_seen, errors);
    $display("covered every error status, full and empty slots, reads up to capacity");
    if (errors == 0 && pending_rsps.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
